// ===== rtl/core/sipu_pkg.sv =====
package sipu_pkg;

   // meet_status codes
   localparam logic [1:0] MEET_NONE      = 2'd0;
   localparam logic [1:0] MEET_POINT     = 2'd1;
   localparam logic [1:0] MEET_COLLINEAR = 2'd2;

endpackage

// ===== rtl/core/sipu_cell.sv =====
// One digit of the two point divisions (x and y lanes).
// rem' = 2*rem + bit*n1, digit 0..2 taken off against den.
module sipu_cell #(
   parameter int W   = 16,
   parameter int N   = 35,
   parameter int SB  = 36,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   output logic          out_valid,
   input  logic          out_ready,
   input  logic [N-1:0]  den_i,
   input  logic [N-1:0]  n1_i,
   input  logic [W:0]    mx_i,
   input  logic [W:0]    my_i,
   input  logic [N-1:0]  rx_i,
   input  logic [N-1:0]  ry_i,
   input  logic [W:0]    qx_i,
   input  logic [W:0]    qy_i,
   input  logic [SB-1:0] side_i,
   output logic [N-1:0]  den_o,
   output logic [N-1:0]  n1_o,
   output logic [W:0]    mx_o,
   output logic [W:0]    my_o,
   output logic [N-1:0]  rx_o,
   output logic [N-1:0]  ry_o,
   output logic [W:0]    qx_o,
   output logic [W:0]    qy_o,
   output logic [SB-1:0] side_o
);

   localparam int BIT = W - IDX;

   logic          valid_ff;
   logic [N-1:0]  den_ff, n1_ff, rx_ff, ry_ff;
   logic [W:0]    mx_ff, my_ff, qx_ff, qy_ff;
   logic [SB-1:0] side_ff;
   logic [N+W:0]  lane_x_in, lane_y_in;

   function automatic logic [N+W:0] div_step(input logic [N-1:0] rem,
                                             input logic [W:0] q,
                                             input logic b,
                                             input logic [N-1:0] den,
                                             input logic [N-1:0] n1);
      logic [N+1:0] t, d1, d2;
      logic [W:0]   qn;
      logic [N-1:0] rn;
      t  = {1'b0, rem, 1'b0} + (b ? {2'b00, n1} : '0);
      d1 = {2'b00, den};
      d2 = {1'b0, den, 1'b0};
      if (t >= d2) begin
         rn = N'(t - d2);
         qn = {q[W-1:0], 1'b0} + (W+1)'(2);
      end else if (t >= d1) begin
         rn = N'(t - d1);
         qn = {q[W-1:0], 1'b0} + (W+1)'(1);
      end else begin
         rn = N'(t);
         qn = {q[W-1:0], 1'b0};
      end
      return {qn, rn};
   endfunction

   assign lane_x_in = div_step(rx_i, qx_i, mx_i[BIT], den_i, n1_i);
   assign lane_y_in = div_step(ry_i, qy_i, my_i[BIT], den_i, n1_i);

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         den_ff  <= den_i;
         n1_ff   <= n1_i;
         mx_ff   <= mx_i;
         my_ff   <= my_i;
         side_ff <= side_i;
         {qx_ff, rx_ff} <= lane_x_in;
         {qy_ff, ry_ff} <= lane_y_in;
      end
   end

   assign den_o  = den_ff;
   assign n1_o   = n1_ff;
   assign mx_o   = mx_ff;
   assign my_o   = my_ff;
   assign rx_o   = rx_ff;
   assign ry_o   = ry_ff;
   assign qx_o   = qx_ff;
   assign qy_o   = qy_ff;
   assign side_o = side_ff;

endmodule

// ===== rtl/core/segment_intersection_point_unit.sv =====
// Channel | ports          | tdata fields (low bit up)
// req     | req_t*         | a_start_x, a_start_y, a_end_x, a_end_y,
//         |                | b_start_x, b_start_y, b_end_x, b_end_y
// rsp     | rsp_t*         | meet_status, cross_x, cross_y, zero pad
//
// One beat per cycle sustained while rsp_tready stays high. Four front
// stages (differences, six products, den/n1/n2, sign fold and range test),
// COORD_WIDTH+1 division cells, one correction/output register.
// Each stage holds its own valid and stalls only when full and blocked, so
// bubbles collapse and a beat is taken while a result waits at rsp.
// Synchronous active-high reset clears the valids only.
module segment_intersection_point_unit #(
   parameter int COORD_WIDTH = 16,
   localparam int RSP_TW = ((2 + 2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   input  logic [8*COORD_WIDTH-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // meet_status[1:0], cross_x, cross_y, zero pad
   output logic [RSP_TW-1:0]        rsp_tdata
);

   localparam int W  = COORD_WIDTH;
   localparam int P  = 2 * W + 2;   // product width
   localparam int N  = 2 * W + 3;   // den / numerator width
   localparam int SB = 2 * W + 4;   // sideband: x1, y1, sign dax, sign day, status

   // ---------------- stage 1: differences
   logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   assign x1 = req_tdata[W-1:0];
   assign y1 = req_tdata[2*W-1:W];
   assign x2 = req_tdata[3*W-1:2*W];
   assign y2 = req_tdata[4*W-1:3*W];
   assign x3 = req_tdata[5*W-1:4*W];
   assign y3 = req_tdata[6*W-1:5*W];
   assign x4 = req_tdata[7*W-1:6*W];
   assign y4 = req_tdata[8*W-1:7*W];

   logic                v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic                e1, e2, e3, e4, eo;
   logic signed [W:0]   dax1_ff, day1_ff, dbx1_ff, dby1_ff, ex1_ff, ey1_ff;
   logic signed [W-1:0] x1_1_ff, y1_1_ff;

   assign e1 = !v1_ff || e2;
   assign req_tready = e1;

   always_ff @(posedge clock) begin
      if (e1 && req_tvalid) begin
         dax1_ff <= {x2[W-1], x2} - {x1[W-1], x1};
         day1_ff <= {y2[W-1], y2} - {y1[W-1], y1};
         dbx1_ff <= {x4[W-1], x4} - {x3[W-1], x3};
         dby1_ff <= {y4[W-1], y4} - {y3[W-1], y3};
         ex1_ff  <= {x1[W-1], x1} - {x3[W-1], x3};
         ey1_ff  <= {y1[W-1], y1} - {y3[W-1], y3};
         x1_1_ff <= x1;
         y1_1_ff <= y1;
      end
   end

   // ---------------- stage 2: products
   logic signed [P-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [W:0]   dax2_ff, day2_ff;
   logic signed [W-1:0] x1_2_ff, y1_2_ff;

   assign e2 = !v2_ff || e3;

   always_ff @(posedge clock) begin
      if (e2 && v1_ff) begin
         pa_ff   <= P'(dby1_ff * dax1_ff);
         pb_ff   <= P'(dbx1_ff * day1_ff);
         pc_ff   <= P'(dbx1_ff * ey1_ff);
         pd_ff   <= P'(dby1_ff * ex1_ff);
         pe_ff   <= P'(dax1_ff * ey1_ff);
         pf_ff   <= P'(day1_ff * ex1_ff);
         dax2_ff <= dax1_ff;
         day2_ff <= day1_ff;
         x1_2_ff <= x1_1_ff;
         y1_2_ff <= y1_1_ff;
      end
   end

   // ---------------- stage 3: den, n1, n2
   logic signed [N-1:0] den3_ff, n1_3_ff, n2_3_ff;
   logic signed [W:0]   dax3_ff, day3_ff;
   logic signed [W-1:0] x1_3_ff, y1_3_ff;

   assign e3 = !v3_ff || e4;

   always_ff @(posedge clock) begin
      if (e3 && v2_ff) begin
         den3_ff <= {pa_ff[P-1], pa_ff} - {pb_ff[P-1], pb_ff};
         n1_3_ff <= {pc_ff[P-1], pc_ff} - {pd_ff[P-1], pd_ff};
         n2_3_ff <= {pe_ff[P-1], pe_ff} - {pf_ff[P-1], pf_ff};
         dax3_ff <= dax2_ff;
         day3_ff <= day2_ff;
         x1_3_ff <= x1_2_ff;
         y1_3_ff <= y1_2_ff;
      end
   end

   // ---------------- stage 4: fold sign of den, range test, status
   logic signed [N-1:0] dn_in, n1n_in, n2n_in;
   logic [1:0]          st_in;
   logic [N-1:0]        den4_ff, n1_4_ff;
   logic [W:0]          mx4_ff, my4_ff;
   logic [SB-1:0]       side4_ff;

   always_comb begin
      dn_in  = den3_ff[N-1] ? -den3_ff : den3_ff;
      n1n_in = den3_ff[N-1] ? -n1_3_ff : n1_3_ff;
      n2n_in = den3_ff[N-1] ? -n2_3_ff : n2_3_ff;
      if (den3_ff == '0) begin
         st_in = (n1_3_ff == '0 && n2_3_ff == '0) ? sipu_pkg::MEET_COLLINEAR
                                                  : sipu_pkg::MEET_NONE;
      end else if (!n1n_in[N-1] && !(dn_in < n1n_in) &&
                   !n2n_in[N-1] && !(dn_in < n2n_in)) begin
         st_in = sipu_pkg::MEET_POINT;
      end else begin
         st_in = sipu_pkg::MEET_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (e4 && v3_ff) begin
         den4_ff  <= dn_in;
         n1_4_ff  <= n1n_in;
         mx4_ff   <= dax3_ff[W] ? -dax3_ff : dax3_ff;
         my4_ff   <= day3_ff[W] ? -day3_ff : day3_ff;
         side4_ff <= {st_in, day3_ff[W], dax3_ff[W], y1_3_ff, x1_3_ff};
      end
   end

   // ---------------- division cells, one quotient digit each
   logic          cv [0:W+1];
   logic          cr [0:W+1];
   logic [N-1:0]  cden [0:W+1];
   logic [N-1:0]  cn1  [0:W+1];
   logic [W:0]    cmx  [0:W+1];
   logic [W:0]    cmy  [0:W+1];
   logic [N-1:0]  crx  [0:W+1];
   logic [N-1:0]  cry  [0:W+1];
   logic [W:0]    cqx  [0:W+1];
   logic [W:0]    cqy  [0:W+1];
   logic [SB-1:0] cside [0:W+1];

   assign cv[0]    = v4_ff;
   assign e4       = !v4_ff || cr[0];
   assign cden[0]  = den4_ff;
   assign cn1[0]   = n1_4_ff;
   assign cmx[0]   = mx4_ff;
   assign cmy[0]   = my4_ff;
   assign crx[0]   = '0;
   assign cry[0]   = '0;
   assign cqx[0]   = '0;
   assign cqy[0]   = '0;
   assign cside[0] = side4_ff;
   assign cr[W+1]  = eo;

   for (genvar k = 0; k <= W; k++) begin : g_cell
      sipu_cell #(.W(W), .N(N), .SB(SB), .IDX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[k]),
         .in_ready  (cr[k]),
         .out_valid (cv[k+1]),
         .out_ready (cr[k+1]),
         .den_i     (cden[k]),
         .n1_i      (cn1[k]),
         .mx_i      (cmx[k]),
         .my_i      (cmy[k]),
         .rx_i      (crx[k]),
         .ry_i      (cry[k]),
         .qx_i      (cqx[k]),
         .qy_i      (cqy[k]),
         .side_i    (cside[k]),
         .den_o     (cden[k+1]),
         .n1_o      (cn1[k+1]),
         .mx_o      (cmx[k+1]),
         .my_o      (cmy[k+1]),
         .rx_o      (crx[k+1]),
         .ry_o      (cry[k+1]),
         .qx_o      (cqx[k+1]),
         .qy_o      (cqy[k+1]),
         .side_o    (cside[k+1])
      );
   end

   // ---------------- output: x1 +/- (q + r/den), truncated toward zero
   logic [SB-1:0]         fs;
   logic [1:0]            fst;
   logic signed [W+1:0]   ax, ay, rxo, ryo;
   logic [1:0]            st_ff;
   logic [W-1:0]          cx_ff, cy_ff;

   function automatic logic signed [W+1:0] trunc_pt(input logic signed [W-1:0] base,
                                                    input logic [W:0] q,
                                                    input logic neg,
                                                    input logic frac);
      logic signed [W+1:0] b, s;
      b = {{2{base[W-1]}}, base};
      if (!neg) begin
         s = b + $signed({1'b0, q});
         return (frac && s[W+1]) ? s + (W+2)'(1) : s;
      end
      s = b - $signed({1'b0, q});
      return (frac && !s[W+1] && s != '0) ? s - (W+2)'(1) : s;
   endfunction

   always_comb begin
      fs  = cside[W+1];
      fst = fs[SB-1:SB-2];
      ax  = trunc_pt(fs[W-1:0], cqx[W+1], fs[2*W], crx[W+1] != '0);
      ay  = trunc_pt(fs[2*W-1:W], cqy[W+1], fs[2*W+1], cry[W+1] != '0);
      rxo = (fst == sipu_pkg::MEET_POINT) ? ax : '0;
      ryo = (fst == sipu_pkg::MEET_POINT) ? ay : '0;
   end

   assign eo = !vo_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (eo && cv[W+1]) begin
         st_ff <= fst;
         cx_ff <= rxo[W-1:0];
         cy_ff <= ryo[W-1:0];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (e1) v1_ff <= req_tvalid;
         if (e2) v2_ff <= v1_ff;
         if (e3) v3_ff <= v2_ff;
         if (e4) v4_ff <= v3_ff;
         if (eo) vo_ff <= cv[W+1];
      end
   end

   assign rsp_tvalid = vo_ff;

   // pad may be empty for some widths
   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[2*W+1:0] = {cy_ff, cx_ff, st_ff};
   end

`ifndef SYNTHESIS
   // no point means zero coordinates
   a_zero_no_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff != sipu_pkg::MEET_POINT |-> cx_ff == '0 && cy_ff == '0)
      else $error("coordinates nonzero without a meeting point");

   // status code 3 is never produced
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> st_ff != 2'd3)
      else $error("undefined meet_status");

   // an empty output register opens the whole pipe
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
`endif

endmodule

// ===== test/segment_intersection_point_unit_tb.sv =====
module segment_intersection_point_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW     = 16;
   localparam int RSP_TW = ((2 + 2 * CW + 7) / 8) * 8;
   localparam int LAT    = CW + 6;

   // one expected answer per segment pair
   typedef struct packed {
      logic [1:0]    status;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
   } meet_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   logic [8*CW-1:0]      req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // meet_status[1:0], cross_x, cross_y, zero pad
   logic [RSP_TW-1:0]    rsp_tdata;

   meet_type meet_queue[$];
   int    err_count = 0;
   // idle percent on each side; 0 gives a stretch with no bubbles
   int    req_idle_pct = 26;
   int    rsp_idle_pct = 26;
   bit    rsp_hold = 1'b0;

   always #6 clock = ~clock;

   segment_intersection_point_unit #(.COORD_WIDTH(CW)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // exact predictor, wide signed math; product terms stay well inside 80 bits
   function automatic meet_type meet_predict(input logic [8*CW-1:0] d);
      logic signed [79:0] x1, y1, x2, y2, x3, y3, x4, y4;
      logic signed [79:0] dax, day, dbx, dby, ex, ey, den, n1, n2, nx, ny;
      meet_type r;
      x1 = $signed(d[0*CW +: CW]); y1 = $signed(d[1*CW +: CW]);
      x2 = $signed(d[2*CW +: CW]); y2 = $signed(d[3*CW +: CW]);
      x3 = $signed(d[4*CW +: CW]); y3 = $signed(d[5*CW +: CW]);
      x4 = $signed(d[6*CW +: CW]); y4 = $signed(d[7*CW +: CW]);
      dax = x2 - x1; day = y2 - y1; dbx = x4 - x3; dby = y4 - y3;
      ex = x1 - x3; ey = y1 - y3;
      den = dby * dax - dbx * day;
      n1  = dbx * ey - dby * ex;
      n2  = dax * ey - day * ex;
      r = '{sipu_pkg::MEET_NONE, '0, '0};
      if (den == 0) begin
         if (n1 == 0 && n2 == 0) r.status = sipu_pkg::MEET_COLLINEAR;
      end else begin
         if (den < 0) begin
            den = -den; n1 = -n1; n2 = -n2;
         end
         if (n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den) begin
            nx = x1 * den + n1 * dax;
            ny = y1 * den + n1 * day;
            r.status = sipu_pkg::MEET_POINT;
            // SV signed division truncates toward zero
            r.px = CW'(nx / den);
            r.py = CW'(ny / den);
         end
      end
      return r;
   endfunction

   // one beat into the block; prediction queued at acceptance
   task automatic send_pair(input logic [8*CW-1:0] d);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      meet_queue = {meet_queue, meet_predict(d)};
   endtask

   function automatic logic [8*CW-1:0] pack8(input int v[8]);
      logic [8*CW-1:0] d;
      for (int i = 0; i < 8; i++) d[i*CW +: CW] = CW'(v[i]);
      return d;
   endfunction

   function automatic int rcoord(input int span);
      if (span == 0) return $signed(CW'($urandom));
      return $urandom_range(2 * span) - span;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (meet_queue.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   // corners, crossing, parallel, collinear, endpoint touch, degenerate
   task automatic test_directed();
      int mx = (1 <<< (CW - 1)) - 1;
      int mn = -(1 <<< (CW - 1));
      send_pair(pack8('{0, 0, 10, 10, 0, 10, 10, 0}));
      send_pair(pack8('{0, 0, 10, 0, 0, 5, 10, 5}));
      send_pair(pack8('{0, 0, 10, 10, 2, 2, 30, 30}));
      send_pair(pack8('{0, 0, 10, 10, 20, 20, 30, 30}));
      send_pair(pack8('{0, 0, 10, 0, 10, 0, 10, 9}));
      send_pair(pack8('{0, 0, 10, 0, 0, 0, 0, -9}));
      send_pair(pack8('{3, 4, 3, 4, 0, 0, 9, 0}));
      send_pair(pack8('{3, 4, 3, 4, 3, 4, 3, 4}));
      send_pair(pack8('{0, 0, 3, 1, 0, 1, 3, 0}));
      send_pair(pack8('{-7, -3, 2, 5, -1, 4, 1, -6}));
      send_pair(pack8('{mn, mn, mx, mx, mn, mx, mx, mn}));
      send_pair(pack8('{mx, mx, mn, mn, mx, mn, mn, mx}));
      send_pair(pack8('{mn, mn, mn, mn, mn, mn, mn, mn}));
      send_pair(pack8('{mx, mx, mx, mx, mx, mx, mx, mx}));
      send_pair(pack8('{mn, 0, mx, 1, mn, 1, mx, 0}));
      send_pair(pack8('{-1, -1, -1, -1, 0, 0, 0, 0}));
      send_pair(pack8('{0, 0, 1, 0, 5, 5, 6, 5}));
      send_pair(pack8('{0, 0, 10, 0, 11, -1, 11, 1}));
   endtask

   // mostly small boxes so crossings and touches are common
   task automatic test_random(input int n);
      int v[8];
      int span;
      for (int k = 0; k < n; k++) begin
         if (k == n / 3) begin
            req_idle_pct = 0; rsp_idle_pct = 0;
         end
         if (k == n / 3 + 80) begin
            req_idle_pct = 26; rsp_idle_pct = 26;
         end
         case ($urandom_range(3))
            0: span = 0;
            1: span = 8;
            2: span = 100;
            default: span = 2000;
         endcase
         for (int i = 0; i < 8; i++) v[i] = rcoord(span);
         // share an endpoint or reuse a line now and then
         case ($urandom_range(7))
            0: begin v[4] = v[2]; v[5] = v[3]; end
            1: begin v[4] = v[0]; v[5] = v[1]; v[6] = v[2]; v[7] = v[3]; end
            2: begin
               v[4] = v[0] + 2 * (v[2] - v[0]); v[5] = v[1] + 2 * (v[3] - v[1]);
               v[4] = $signed(CW'(v[4])); v[5] = $signed(CW'(v[5]));
            end
            default: ;
         endcase
         send_pair(pack8(v));
      end
   endtask

   // sink stalls for a long stretch while the source keeps offering beats
   task automatic test_backpressure();
      rsp_hold = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            rsp_hold = 1'b0;
         end
         test_random(60);
      join
      wait_drained();
   endtask

   // sink side
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      meet_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[1:0], rsp_tdata[2 +: CW], rsp_tdata[2 + CW +: CW]};
         if (meet_queue.size() == 0) begin
            $display("%0t: unexpected beat %h", $realtime, rsp_tdata);
            err_count++;
         end else begin
            exp_r = meet_queue.pop_front();
            if (got.status !== exp_r.status) begin
               $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
               err_count++;
            end
            if (got.px !== exp_r.px) begin
               $display("%0t: cross_x exp %0d got %0d", $realtime,
                        $signed(exp_r.px), $signed(got.px));
               err_count++;
            end
            if (got.py !== exp_r.py) begin
               $display("%0t: cross_y exp %0d got %0d", $realtime,
                        $signed(exp_r.py), $signed(got.py));
               err_count++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();   // source pauses until everything is back
      test_random(470);
      test_backpressure();
      wait_drained();
      if (err_count == 0 && meet_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/sipu_pkg.sv
rtl/core/sipu_cell.sv
rtl/core/segment_intersection_point_unit.sv
test/segment_intersection_point_unit_tb.sv
